FILE: hw/rtl/load_cell_average_and_weigh_assert.svh
// ----------------------------------------------------------------------------
// Load cell average and weigh: assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_AVERAGE_AND_WEIGH_ASSERT_SVH
`define LOAD_CELL_AVERAGE_AND_WEIGH_ASSERT_SVH

`ifndef SYNTH
`define LCAW_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcaw assertion failed");
`define LCAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcaw assertion failed");
`else
`define LCAW_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define LCAW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/lcaw_pkg.sv
// ----------------------------------------------------------------------------
// Load cell average and weigh: package
// Register codes, reset values, fixed widths and the sequencer state type.
// ----------------------------------------------------------------------------
package lcaw_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int AVG_OUT_W  = 24;
  localparam int WEIGHT_W   = 34;
  localparam int WIN_W      = 8;
  localparam int SCALE_W    = 32;
  localparam int CNT_W      = 9;
  localparam int WIN_FULL   = 256;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAM_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAM_OFFSET   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_SCALE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAIN_OFFSET  = 3'd4;

  localparam logic [WIN_W-1:0]   WINDOW_LENGTH_RST = 8'd20;
  localparam logic [SCALE_W-1:0] GRAM_SCALE_RST    = 32'd1291502;
  localparam logic [SCALE_W-1:0] GRAM_OFFSET_RST   = 32'd9430;
  localparam logic [SCALE_W-1:0] GRAIN_SCALE_RST   = 32'd198810;
  localparam logic [SCALE_W-1:0] GRAIN_OFFSET_RST  = 32'd1449;

  localparam int FAST_DIVISOR = 5;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SUM,
    S_DA_GO,
    S_DA_WAIT,
    S_MUL_MG,
    S_MUL_DG,
    S_WEIGH_DG,
    S_OUT
  } state_t;

endpackage

FILE: hw/rtl/lcaw_divider.sv
// ----------------------------------------------------------------------------
// Load cell average and weigh: serial divider
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module lcaw_divider #(
  parameter int DIVIDEND_W = 33,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic                  done
);

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIVISOR_W:0]    trial;
  logic                  qbit;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[DIVIDEND_W-1]};
    qbit     = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = DIVISOR_W'(trial - {1'b0, dsr_r});
        qbit    = 1'b1;
      end else begin
        rem_nxt = DIVISOR_W'(trial);
      end
      quo_nxt = {quo_r[DIVIDEND_W-2:0], qbit};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

FILE: hw/rtl/load_cell_average_and_weigh.sv
// ----------------------------------------------------------------------------
// Load cell average and weigh: top level
// Sample ring with window average, fast average and two calibrated weights.
// ----------------------------------------------------------------------------
// After reset the block clears the sample ring, one entry a cycle, with
// in_ready low; configuration writes are taken at any time. Each sample
// then walks the last N ring entries, where N is the window length (a
// length of zero means 256, capped at RING_DEPTH), through the ring's
// single read port one entry a cycle. The window average comes from a
// bit-serial divider, and the fast average is a reciprocal multiply done
// while the divider starts. The two weights follow in turn: the gram
// product, then the gram weight with the grain product, then the grain
// weight; the output load and the next accept come last. One sample is in
// work at a time and in_ready is low while it is; a finished result waits
// in the output register while the next sample is taken, and a second
// result holds the block in S_OUT until that register is free.
`include "load_cell_average_and_weigh_assert.svh"

module load_cell_average_and_weigh #(
  parameter int RING_DEPTH          = 256,
  parameter int SAMPLE_BITS         = 24,
  parameter int SCALE_FRACTION_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [SAMPLE_BITS-1:0]                in_raw_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lcaw_pkg::AVG_OUT_W-1:0]        out_window_average,
  output logic [lcaw_pkg::AVG_OUT_W-1:0]        out_fast_average,
  output logic signed [lcaw_pkg::WEIGHT_W-1:0]  out_weight_milligrams,
  output logic signed [lcaw_pkg::WEIGHT_W-1:0]  out_weight_decigrains,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [lcaw_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lcaw_pkg::CFG_DATA_W-1:0]       cfg_data
);

  import lcaw_pkg::*;

  localparam int AW         = $clog2(RING_DEPTH);
  localparam int SUM_W      = SAMPLE_BITS + CNT_W;
  localparam int PROD_W     = SAMPLE_BITS + SCALE_W;
  localparam int FN_W       = SAMPLE_BITS + 3;
  localparam int FAST_SHIFT = FN_W + 2;
  localparam logic [AW-1:0]    LAST_IDX = AW'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] RING_CAP =
    CNT_W'((RING_DEPTH < WIN_FULL) ? RING_DEPTH : WIN_FULL);
  localparam logic [FN_W-1:0]  FAST_RECIP =
    FN_W'(((64'd1 << FAST_SHIFT) + 64'(FAST_DIVISOR - 1)) / 64'(FAST_DIVISOR));

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata_r;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata;

  logic [AW-1:0]          wp_r, wp_nxt, wp_inc;
  logic [AW-1:0]          clr_r, clr_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  logic [CNT_W-1:0]       iss_r, iss_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt, count_raw, count_sel;
  logic                   rdv_r, rdv_nxt;
  logic [SUM_W-1:0]       sum_r, sum_nxt;
  logic [FN_W-1:0]        fast_num_r, fast_num_nxt;
  logic [2*FN_W-1:0]      fast_prod;
  logic [SAMPLE_BITS-1:0] fast_r, fast_nxt;
  logic [SAMPLE_BITS-1:0] avg_r, avg_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [SCALE_W-1:0]     mul_scale;
  logic [WEIGHT_W-1:0]    mg_r, mg_nxt;
  logic [WEIGHT_W-1:0]    dg_r, dg_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [AVG_OUT_W-1:0]   out_avg_r, out_avg_nxt;
  logic [AVG_OUT_W-1:0]   out_fast_r, out_fast_nxt;
  logic [WEIGHT_W-1:0]    out_mg_r, out_mg_nxt;
  logic [WEIGHT_W-1:0]    out_dg_r, out_dg_nxt;

  logic [WIN_W-1:0]       window_length_r;
  logic [SCALE_W-1:0]     gram_scale_r, gram_offset_r;
  logic [SCALE_W-1:0]     grain_scale_r, grain_offset_r;

  logic                   in_xfer;
  logic                   div_start, div_done;
  logic [SUM_W-1:0]       div_dividend, div_quotient;
  logic [CNT_W-1:0]       div_divisor;

  function automatic logic [WEIGHT_W-1:0] weigh(input logic [PROD_W-1:0] prod,
                                                input logic [SCALE_W-1:0] tare);
    logic [PROD_W-1:0] scaled;
    scaled = prod >> SCALE_FRACTION_BITS;
    return WEIGHT_W'(scaled) - {{(WEIGHT_W - SCALE_W){tare[SCALE_W-1]}}, tare};
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign wp_inc    = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
  assign count_raw = (window_length_r == '0) ? CNT_W'(WIN_FULL)
                                             : {1'b0, window_length_r};
  assign count_sel = (count_raw > RING_CAP) ? RING_CAP : count_raw;

  assign mem_we    = (state_r == S_CLEAR) || in_xfer;
  assign mem_waddr = (state_r == S_CLEAR) ? clr_r : wp_inc;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : in_raw_sample;

  assign div_start    = (state_r == S_DA_GO);
  assign div_dividend = sum_r;
  assign div_divisor  = count_r;

  assign fast_prod = {{FN_W{1'b0}}, fast_num_r} * {{FN_W{1'b0}}, FAST_RECIP};

  assign mul_scale = (state_r == S_MUL_MG) ? gram_scale_r : grain_scale_r;
  assign prod_nxt  = {{SCALE_W{1'b0}}, avg_r} * {{SAMPLE_BITS{1'b0}}, mul_scale};

  lcaw_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[mem_waddr] <= mem_wdata;
    end
    rdata_r <= ring[pos_r];
  end

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    clr_nxt       = clr_r;
    pos_nxt       = pos_r;
    iss_nxt       = iss_r;
    count_nxt     = count_r;
    rdv_nxt       = 1'b0;
    sum_nxt       = sum_r;
    fast_num_nxt  = fast_num_r;
    fast_nxt      = fast_r;
    avg_nxt       = avg_r;
    mg_nxt        = mg_r;
    dg_nxt        = dg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_avg_nxt   = out_avg_r;
    out_fast_nxt  = out_fast_r;
    out_mg_nxt    = out_mg_r;
    out_dg_nxt    = out_dg_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          wp_nxt       = wp_inc;
          pos_nxt      = wp_inc;
          iss_nxt      = '0;
          sum_nxt      = '0;
          count_nxt    = count_sel;
          fast_num_nxt = {1'b0, fast_r, 2'b00} + {3'b000, in_raw_sample};
          state_nxt    = S_SUM;
        end
      end
      S_SUM: begin
        if (iss_r != count_r) begin
          rdv_nxt = 1'b1;
          iss_nxt = iss_r + 1'b1;
          pos_nxt = (pos_r == '0) ? LAST_IDX : pos_r - 1'b1;
        end
        if (rdv_r) begin
          sum_nxt = sum_r + SUM_W'(rdata_r);
        end
        if ((iss_r == count_r) && !rdv_r) begin
          state_nxt = S_DA_GO;
        end
      end
      S_DA_GO: begin
        fast_nxt  = SAMPLE_BITS'(fast_prod >> FAST_SHIFT);
        state_nxt = S_DA_WAIT;
      end
      S_DA_WAIT: begin
        if (div_done) begin
          avg_nxt   = SAMPLE_BITS'(div_quotient);
          state_nxt = S_MUL_MG;
        end
      end
      S_MUL_MG: begin
        state_nxt = S_MUL_DG;
      end
      S_MUL_DG: begin
        mg_nxt    = weigh(prod_r, gram_offset_r);
        state_nxt = S_WEIGH_DG;
      end
      S_WEIGH_DG: begin
        dg_nxt    = weigh(prod_r, grain_offset_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = AVG_OUT_W'(avg_r);
          out_fast_nxt  = AVG_OUT_W'(fast_r);
          out_mg_nxt    = mg_r;
          out_dg_nxt    = dg_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_CLEAR;
      clr_r           <= '0;
      wp_r            <= '0;
      rdv_r           <= 1'b0;
      fast_r          <= '0;
      out_valid_r     <= 1'b0;
      window_length_r <= WINDOW_LENGTH_RST;
      gram_scale_r    <= GRAM_SCALE_RST;
      gram_offset_r   <= GRAM_OFFSET_RST;
      grain_scale_r   <= GRAIN_SCALE_RST;
      grain_offset_r  <= GRAIN_OFFSET_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      wp_r        <= wp_nxt;
      rdv_r       <= rdv_nxt;
      fast_r      <= fast_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_WINDOW_LENGTH: window_length_r <= cfg_data[WIN_W-1:0];
          CFG_GRAM_SCALE:    gram_scale_r    <= cfg_data;
          CFG_GRAM_OFFSET:   gram_offset_r   <= cfg_data;
          CFG_GRAIN_SCALE:   grain_scale_r   <= cfg_data;
          CFG_GRAIN_OFFSET:  grain_offset_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    iss_r      <= iss_nxt;
    count_r    <= count_nxt;
    sum_r      <= sum_nxt;
    fast_num_r <= fast_num_nxt;
    avg_r      <= avg_nxt;
    prod_r     <= prod_nxt;
    mg_r       <= mg_nxt;
    dg_r       <= dg_nxt;
    out_avg_r  <= out_avg_nxt;
    out_fast_r <= out_fast_nxt;
    out_mg_r   <= out_mg_nxt;
    out_dg_r   <= out_dg_nxt;
  end

  assign out_valid             = out_valid_r;
  assign out_window_average    = out_avg_r;
  assign out_fast_average      = out_fast_r;
  assign out_weight_milligrams = out_mg_r;
  assign out_weight_decigrains = out_dg_r;

  `LCAW_ASSERT_NEXT(a_accept_starts_walk, clk, rst_n, in_xfer, (state_r == S_SUM) && (iss_r == '0) && (sum_r == '0))
  `LCAW_ASSERT_SAME(a_walk_bound, clk, rst_n, state_r == S_SUM, (iss_r <= count_r) && (count_r != '0))
  `LCAW_ASSERT_SAME(a_div_done_waited, clk, rst_n, div_done, state_r == S_DA_WAIT)

endmodule
